>>> rtl/core/gcd_pkg.sv
// Shared constants, fixed-point types and stage records for the great-circle distance unit.
`default_nettype none
package gcd_pkg;

  // Internal reals are Q40.
  localparam int FRAC = 40;
  // Unsigned magnitude width for trig values (below 4.0).
  localparam int UW = 42;
  // Signed width of the running sine sum.
  localparam int SW = 43;
  // Width of root and arcsine values (below 1.0).
  localparam int RW = 40;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_DEG_Q60 = PI_Q60 / 64'd180;
  localparam int PI_DEG_W = 55;
  localparam logic [RW:0] PI_HALF_Q40 = (RW + 1)'(PI_Q60 >> 21);
  localparam logic [RW:0] FIX_ONE = {1'b1, {RW{1'b0}}};
  localparam logic [RW:0] FIX_HALF = {2'b01, {(RW - 1){1'b0}}};

  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  typedef logic [UW-1:0] umag_t;
  typedef logic signed [SW-1:0] sfix_t;
  typedef logic [RW-1:0] ufrac_t;

  // Record that travels along the sine series cells.
  typedef struct packed {
    logic  neg;
    sfix_t sum;
    umag_t x2;
  } trig_pay_t;

  // Record that travels along the square root cells.
  typedef struct packed {
    logic          flip;
    ufrac_t        rad;
    logic [RW+1:0] rem;
    ufrac_t        root;
  } sqrt_st_t;

  // Record that travels along the arcsine series cells.
  typedef struct packed {
    logic        flip;
    ufrac_t      s2;
    logic [RW:0] sum;
  } asin_pay_t;

endpackage
`default_nettype wire

>>> rtl/core/gcd_mul.sv
// Two-stage unsigned multiplier with a fixed right shift and a side record carried alongside.
`default_nettype none
module gcd_mul #(
  parameter int AW = 42,
  parameter int BW = 42,
  parameter int SHIFT = 40,
  parameter int OW = 42,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [OW-1:0] prod,
  output logic [PW-1:0] out_pay
);
  localparam int AX = (AW > 32) ? AW : 33;
  localparam int BX = (BW > 32) ? BW : 33;
  localparam int AH = AX - 32;
  localparam int BH = BX - 32;
  localparam int FW = AX + BX;

  logic [AX-1:0]      ax;
  logic [BX-1:0]      bx;
  logic [63:0]        p_ll;
  logic [BH+31:0]     p_lh;
  logic [AH+31:0]     p_hl;
  logic [AH+BH-1:0]   p_hh;
  logic               v1;
  logic [PW-1:0]      pay1;
  logic [FW-1:0]      full;

  assign ax = AX'(a);
  assign bx = BX'(b);

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  // First stage forms the four partial products.
  always_ff @(posedge clk) begin
    p_ll <= ax[31:0] * bx[31:0];
    p_lh <= ax[31:0] * bx[BX-1:32];
    p_hl <= ax[AX-1:32] * bx[31:0];
    p_hh <= ax[AX-1:32] * bx[BX-1:32];
    pay1 <= in_pay;
  end

  // Second stage sums the partial products and drops the fraction bits.
  assign full = FW'(p_ll) + (FW'(p_lh) << 32) + (FW'(p_hl) << 32) + (FW'(p_hh) << 64);

  always_ff @(posedge clk) begin
    prod <= OW'(full >> SHIFT);
    out_pay <= pay1;
  end

endmodule
`default_nettype wire

>>> rtl/core/gcd_trig_cell.sv
// One sine term: scale by x squared, divide by a constant, add to or take from the sum.
`default_nettype none
module gcd_trig_cell #(
  parameter int N = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  gcd_pkg::umag_t    term_in,
  input  gcd_pkg::trig_pay_t pay_in,
  output logic              out_valid,
  output gcd_pkg::umag_t    term_out,
  output gcd_pkg::trig_pay_t pay_out
);
  import gcd_pkg::*;

  localparam int DIV = (2 * N) * (2 * N + 1);
  localparam int K = UW + 9;
  localparam logic [K-1:0] RECIP =
    K'(((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam bit SUB = (N % 2) == 1;
  localparam int PW = $bits(trig_pay_t);

  logic      v1, v2;
  umag_t     p, q;
  trig_pay_t pay1, pay2, pay_next;
  sfix_t     qs;

  // Term times x squared.
  gcd_mul #(.AW(UW), .BW(UW), .SHIFT(FRAC), .OW(UW), .PW(PW)) u_sq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .a(term_in), .b(pay_in.x2),
    .in_pay(pay_in), .out_valid(v1), .prod(p), .out_pay(pay1)
  );

  // Exact truncating division by the series constant through its reciprocal.
  gcd_mul #(.AW(UW), .BW(K), .SHIFT(K), .OW(UW), .PW(PW)) u_div (
    .clk(clk), .rst(rst), .in_valid(v1), .a(p), .b(RECIP),
    .in_pay(pay1), .out_valid(v2), .prod(q), .out_pay(pay2)
  );

  // Terms alternate in sign.
  always_comb begin
    qs = sfix_t'({1'b0, q});
    pay_next = pay2;
    pay_next.sum = SUB ? pay2.sum - qs : pay2.sum + qs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    term_out <= q;
    pay_out <= pay_next;
  end

endmodule
`default_nettype wire

>>> rtl/core/gcd_sin.sv
// Sine of an angle in scaled degrees: exact range reduction, conversion to radians, series chain.
`default_nettype none
module gcd_sin #(
  parameter int FB = 21,
  parameter int IW = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] angle,
  output logic                 out_valid,
  output gcd_pkg::umag_t       mag,
  output logic                 neg
);
  import gcd_pkg::*;

  localparam int CW = FB + 9;
  localparam int HW = FB + 8;
  localparam int QW = FB + 7;
  localparam int TERMS = 8;
  localparam logic [CW-1:0] FULL = CW'(360) << FB;
  localparam logic [CW-1:0] HALF = CW'(180) << FB;
  localparam logic [HW-1:0] HALF_H = HW'(180) << FB;
  localparam logic [HW-1:0] QUARTER = HW'(90) << FB;

  logic [CW-1:0] wrapped;
  logic [HW-1:0] r1;
  logic [QW-1:0] r2;
  logic          v1, v2, neg1, neg2;
  logic          vx, negx, v3;
  umag_t         xr, x2;
  logic [UW:0]   pay3;

  logic      v_c [0:TERMS];
  umag_t     term_c [0:TERMS];
  trig_pay_t pay_c [0:TERMS];

  // Bring the angle into one turn, then into the lower half-turn with a sign.
  assign wrapped = angle[IW-1] ? CW'(angle) + FULL : CW'(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (wrapped >= HALF) begin
      neg1 <= 1'b1;
      r1 <= HW'(wrapped - HALF);
    end else begin
      neg1 <= 1'b0;
      r1 <= HW'(wrapped);
    end
    // Fold the second quarter onto the first.
    neg2 <= neg1;
    r2 <= (r1 > QUARTER) ? QW'(HALF_H - r1) : QW'(r1);
  end

  // Degrees to Q40 radians.
  gcd_mul #(.AW(QW), .BW(PI_DEG_W), .SHIFT(FB + 20), .OW(UW), .PW(1)) u_rad (
    .clk(clk), .rst(rst), .in_valid(v2), .a(r2), .b(PI_DEG_Q60[PI_DEG_W-1:0]),
    .in_pay(neg2), .out_valid(vx), .prod(xr), .out_pay(negx)
  );

  // Square of the reduced angle.
  gcd_mul #(.AW(UW), .BW(UW), .SHIFT(FRAC), .OW(UW), .PW(UW + 1)) u_x2 (
    .clk(clk), .rst(rst), .in_valid(vx), .a(xr), .b(xr),
    .in_pay({negx, xr}), .out_valid(v3), .prod(x2), .out_pay(pay3)
  );

  // Series chain seeded with the angle itself.
  always_comb begin
    v_c[0] = v3;
    term_c[0] = pay3[UW-1:0];
    pay_c[0].neg = pay3[UW];
    pay_c[0].sum = sfix_t'({1'b0, pay3[UW-1:0]});
    pay_c[0].x2 = x2;
  end

  for (genvar gi = 1; gi <= TERMS; gi++) begin : g_term
    gcd_trig_cell #(.N(gi)) u_cell (
      .clk(clk), .rst(rst), .in_valid(v_c[gi-1]), .term_in(term_c[gi-1]),
      .pay_in(pay_c[gi-1]), .out_valid(v_c[gi]), .term_out(term_c[gi]),
      .pay_out(pay_c[gi])
    );
  end

  // The series sum is never negative on the reduced range.
  assign out_valid = v_c[TERMS];
  assign mag = pay_c[TERMS].sum[UW-1:0];
  assign neg = pay_c[TERMS].neg;

endmodule
`default_nettype wire

>>> rtl/core/gcd_sqrt_cell.sv
// One digit of the restoring square root: brings in two radicand bits and decides one root bit.
`default_nettype none
module gcd_sqrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  gcd_pkg::sqrt_st_t st_in,
  output logic              out_valid,
  output gcd_pkg::sqrt_st_t st_out
);
  import gcd_pkg::*;

  logic [RW+3:0] rem_sh;
  logic [RW+3:0] trial;
  sqrt_st_t      st_next;

  // Trial subtract of 4*root+1 from the shifted remainder.
  always_comb begin
    rem_sh = {st_in.rem, st_in.rad[RW-1:RW-2]};
    trial = (RW + 4)'({st_in.root, 2'b01});
    st_next = st_in;
    st_next.rad = {st_in.rad[RW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      st_next.rem = (RW + 2)'(rem_sh - trial);
      st_next.root = {st_in.root[RW-2:0], 1'b1};
    end else begin
      st_next.rem = (RW + 2)'(rem_sh);
      st_next.root = {st_in.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_out <= st_next;
  end

endmodule
`default_nettype wire

>>> rtl/core/gcd_asin_cell.sv
// One term of the arcsine series: scale the term by s squared and (2n-1)/(2n), add term/(2n+1).
`default_nettype none
module gcd_asin_cell #(
  parameter int N = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  gcd_pkg::ufrac_t    t_in,
  input  gcd_pkg::asin_pay_t pay_in,
  output logic               out_valid,
  output gcd_pkg::ufrac_t    t_out,
  output gcd_pkg::asin_pay_t pay_out
);
  import gcd_pkg::*;

  localparam int K = RW + 7;
  localparam logic [K-1:0] SCALE =
    K'(((64'(2 * N - 1) << K) + 64'(2 * N) - 64'd1) / 64'(2 * N));
  localparam logic [K-1:0] RECIP =
    K'(((64'd1 << K) + 64'(2 * N + 1) - 64'd1) / 64'(2 * N + 1));
  localparam int PW = $bits(asin_pay_t);

  logic       v1, v2, v3;
  ufrac_t     p, tn, q;
  asin_pay_t  pay1, pay2, pay3;
  logic [PW+RW-1:0] rec3;
  asin_pay_t  pay_next;

  // Term times s squared.
  gcd_mul #(.AW(RW), .BW(RW), .SHIFT(FRAC), .OW(RW), .PW(PW)) u_sq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .a(t_in), .b(pay_in.s2),
    .in_pay(pay_in), .out_valid(v1), .prod(p), .out_pay(pay1)
  );

  // Exact floor of p*(2n-1)/(2n).
  gcd_mul #(.AW(RW), .BW(K), .SHIFT(K), .OW(RW), .PW(PW)) u_scale (
    .clk(clk), .rst(rst), .in_valid(v1), .a(p), .b(SCALE),
    .in_pay(pay1), .out_valid(v2), .prod(tn), .out_pay(pay2)
  );

  // Exact floor of the new term divided by 2n+1.
  gcd_mul #(.AW(RW), .BW(K), .SHIFT(K), .OW(RW), .PW(PW + RW)) u_div (
    .clk(clk), .rst(rst), .in_valid(v2), .a(tn), .b(RECIP),
    .in_pay({pay2, tn}), .out_valid(v3), .prod(q), .out_pay(rec3)
  );

  always_comb begin
    pay3 = rec3[PW+RW-1:RW];
    pay_next = pay3;
    pay_next.sum = pay3.sum + (RW + 1)'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    t_out <= rec3[RW-1:0];
    pay_out <= pay_next;
  end

endmodule
`default_nettype wire

>>> rtl/core/great_circle_distance_top.sv
// Haversine great-circle distance unit: trig lanes, radicand stage, root and arcsine cell chains.
// Throughput is one item per cycle; every stage, including each series and root cell, is pipelined.
// The receiver cannot stall: each result shows for one cycle with done and is then gone.
// Synchronous reset clears all valid bits and loads the radius of 6371 km; busy is set by reset.
`default_nettype none
module great_circle_distance_top #(
  parameter int ANGLE_FRACTION_BITS = 20,
  parameter int DISTANCE_FRACTION_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ANGLE_FRACTION_BITS+7:0] first_latitude,
  input  logic signed [ANGLE_FRACTION_BITS+8:0] first_longitude,
  input  logic signed [ANGLE_FRACTION_BITS+7:0] second_latitude,
  input  logic signed [ANGLE_FRACTION_BITS+8:0] second_longitude,
  output logic                                  done,
  output logic [31:0]                           distance,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [15:0]                           cfg_data
);
  import gcd_pkg::*;

  localparam int AFB = ANGLE_FRACTION_BITS;
  localparam int IW = AFB + 10;
  localparam int ROOT_STEPS = RW;
  localparam int ASIN_TERMS = 48;
  localparam int DW = RW + 1 + 17;
  localparam logic signed [IW-1:0] QUARTER = IW'(90) << AFB;

  logic [15:0] radius;
  logic        accept, v_in;
  logic signed [IW-1:0] arg_u, arg_v, arg_c1, arg_c2;

  logic  v_trig, c1_neg, c2_neg;
  umag_t u_mag, v_mag, c1_mag, c2_mag;

  logic  v_h1, v_h2, sign_h1;
  umag_t uu, vv, cc, w;
  logic [UW:0] pay_h2;

  logic signed [UW+1:0] h_sum;
  logic [RW:0]  hc;
  logic         v_h3;

  logic     v_sq [0:ROOT_STEPS];
  sqrt_st_t st_sq [0:ROOT_STEPS];

  logic      v_s2;
  ufrac_t    s2;
  logic [RW:0] pay_s2;

  logic      v_as [0:ASIN_TERMS];
  ufrac_t    t_as [0:ASIN_TERMS];
  asin_pay_t pay_as [0:ASIN_TERMS];

  logic        v_ang, v_d;
  logic [RW:0] ang, sum_f;
  logic [DW-1:0] dprod;

  // Configuration and handshake.
  assign cfg_ready = 1'b1;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      radius <= RADIUS_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        radius <= cfg_data;
      end
    end
  end

  // Capture the item as the four trig arguments.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else begin
      v_in <= accept;
    end
  end

  always_ff @(posedge clk) begin
    arg_u <= IW'(second_latitude) - IW'(first_latitude);
    arg_v <= IW'(second_longitude) - IW'(first_longitude);
    arg_c1 <= IW'(first_latitude) + QUARTER;
    arg_c2 <= IW'(second_latitude) + QUARTER;
  end

  // Half differences carry one more fraction bit, so the halving is exact.
  gcd_sin #(.FB(AFB + 1), .IW(IW)) u_sin_u (
    .clk(clk), .rst(rst), .in_valid(v_in), .angle(arg_u),
    .out_valid(v_trig), .mag(u_mag), .neg()
  );

  gcd_sin #(.FB(AFB + 1), .IW(IW)) u_sin_v (
    .clk(clk), .rst(rst), .in_valid(v_in), .angle(arg_v),
    .out_valid(), .mag(v_mag), .neg()
  );

  // Cosines as sines shifted by a quarter turn.
  gcd_sin #(.FB(AFB), .IW(IW)) u_cos_1 (
    .clk(clk), .rst(rst), .in_valid(v_in), .angle(arg_c1),
    .out_valid(), .mag(c1_mag), .neg(c1_neg)
  );

  gcd_sin #(.FB(AFB), .IW(IW)) u_cos_2 (
    .clk(clk), .rst(rst), .in_valid(v_in), .angle(arg_c2),
    .out_valid(), .mag(c2_mag), .neg(c2_neg)
  );

  // Squares and the cosine product, on magnitudes.
  gcd_mul #(.AW(UW), .BW(UW), .SHIFT(FRAC), .OW(UW), .PW(1)) u_uu (
    .clk(clk), .rst(rst), .in_valid(v_trig), .a(u_mag), .b(u_mag),
    .in_pay(1'b0), .out_valid(), .prod(uu), .out_pay()
  );

  gcd_mul #(.AW(UW), .BW(UW), .SHIFT(FRAC), .OW(UW), .PW(1)) u_vv (
    .clk(clk), .rst(rst), .in_valid(v_trig), .a(v_mag), .b(v_mag),
    .in_pay(1'b0), .out_valid(), .prod(vv), .out_pay()
  );

  gcd_mul #(.AW(UW), .BW(UW), .SHIFT(FRAC), .OW(UW), .PW(1)) u_cc (
    .clk(clk), .rst(rst), .in_valid(v_trig), .a(c1_mag), .b(c2_mag),
    .in_pay(c1_neg ^ c2_neg), .out_valid(v_h1), .prod(cc), .out_pay(sign_h1)
  );

  gcd_mul #(.AW(UW), .BW(UW), .SHIFT(FRAC), .OW(UW), .PW(UW + 1)) u_w (
    .clk(clk), .rst(rst), .in_valid(v_h1), .a(cc), .b(vv),
    .in_pay({sign_h1, uu}), .out_valid(v_h2), .prod(w), .out_pay(pay_h2)
  );

  // Radicand, clamped to [0,1].
  always_comb begin
    if (pay_h2[UW]) begin
      h_sum = $signed({2'b00, pay_h2[UW-1:0]}) - $signed({2'b00, w});
    end else begin
      h_sum = $signed({2'b00, pay_h2[UW-1:0]}) + $signed({2'b00, w});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_h3 <= 1'b0;
      v_sq[0] <= 1'b0;
    end else begin
      v_h3 <= v_h2;
      v_sq[0] <= v_h3;
    end
  end

  always_ff @(posedge clk) begin
    if (h_sum < 0) begin
      hc <= '0;
    end else if (h_sum > $signed({3'b000, FIX_ONE})) begin
      hc <= FIX_ONE;
    end else begin
      hc <= h_sum[RW:0];
    end
    // Above one half the root is taken of the complement.
    st_sq[0].rem <= '0;
    st_sq[0].root <= '0;
    if (hc <= FIX_HALF) begin
      st_sq[0].flip <= 1'b0;
      st_sq[0].rad <= hc[RW-1:0];
    end else begin
      st_sq[0].flip <= 1'b1;
      st_sq[0].rad <= RW'(FIX_ONE - hc);
    end
  end

  // Square root, one root bit per cell.
  for (genvar gi = 1; gi <= ROOT_STEPS; gi++) begin : g_root
    gcd_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .in_valid(v_sq[gi-1]), .st_in(st_sq[gi-1]),
      .out_valid(v_sq[gi]), .st_out(st_sq[gi])
    );
  end

  // Square of the root seeds the arcsine series.
  gcd_mul #(.AW(RW), .BW(RW), .SHIFT(FRAC), .OW(RW), .PW(RW + 1)) u_s2 (
    .clk(clk), .rst(rst), .in_valid(v_sq[ROOT_STEPS]), .a(st_sq[ROOT_STEPS].root),
    .b(st_sq[ROOT_STEPS].root),
    .in_pay({st_sq[ROOT_STEPS].flip, st_sq[ROOT_STEPS].root}),
    .out_valid(v_s2), .prod(s2), .out_pay(pay_s2)
  );

  always_comb begin
    v_as[0] = v_s2;
    t_as[0] = pay_s2[RW-1:0];
    pay_as[0].flip = pay_s2[RW];
    pay_as[0].s2 = s2;
    pay_as[0].sum = (RW + 1)'(pay_s2[RW-1:0]);
  end

  for (genvar gi = 1; gi <= ASIN_TERMS; gi++) begin : g_asin
    gcd_asin_cell #(.N(gi)) u_cell (
      .clk(clk), .rst(rst), .in_valid(v_as[gi-1]), .t_in(t_as[gi-1]),
      .pay_in(pay_as[gi-1]), .out_valid(v_as[gi]), .t_out(t_as[gi]),
      .pay_out(pay_as[gi])
    );
  end

  // Half the central angle, reflected about a quarter turn for large radicands.
  assign sum_f = pay_as[ASIN_TERMS].sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_ang <= 1'b0;
      done <= 1'b0;
    end else begin
      v_ang <= v_as[ASIN_TERMS];
      done <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!pay_as[ASIN_TERMS].flip) begin
      ang <= sum_f;
    end else if (sum_f > PI_HALF_Q40) begin
      ang <= '0;
    end else begin
      ang <= PI_HALF_Q40 - sum_f;
    end
  end

  // Angle times the diameter, then saturate to the output field.
  gcd_mul #(.AW(RW + 1), .BW(17), .SHIFT(FRAC - DISTANCE_FRACTION_BITS), .OW(DW),
            .PW(1)) u_dist (
    .clk(clk), .rst(rst), .in_valid(v_ang), .a(ang), .b({radius, 1'b0}),
    .in_pay(1'b0), .out_valid(v_d), .prod(dprod), .out_pay()
  );

  always_ff @(posedge clk) begin
    distance <= (|dprod[DW-1:32]) ? 32'hFFFF_FFFF : dprod[31:0];
  end

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the great-circle distance unit, with its own fixed-point predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gcd_pkg::*;

  localparam int AFB = 20;
  localparam int DFB = 10;
  localparam int LATENCY = 435;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint DEG = longint'(1) << AFB;
  localparam longint FIX_ONE_L = longint'(1) << 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [AFB+7:0] first_latitude = '0;
  logic signed [AFB+8:0] first_longitude = '0;
  logic signed [AFB+7:0] second_latitude = '0;
  logic signed [AFB+8:0] second_longitude = '0;
  logic done;
  logic [31:0] distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  // Predicted distances, oldest first, and the radius the predictor holds.
  logic [31:0] distance_queue[$];
  logic [15:0] radius_km;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int radius_writes = 0;
  longint cycle_count = 0;
  bit idle_enable = 1'b1;

  great_circle_distance_top #(
    .ANGLE_FRACTION_BITS(AFB),
    .DISTANCE_FRACTION_BITS(DFB)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_latitude(first_latitude),
    .first_longitude(first_longitude),
    .second_latitude(second_latitude),
    .second_longitude(second_longitude),
    .done(done),
    .distance(distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Unsigned 64 x 64 product shifted right, low 64 bits kept.
  function automatic logic [63:0] wide_product_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // Q40 product truncated toward zero.
  function automatic longint q40_mul(longint a, longint b);
    logic [63:0] ma;
    logic [63:0] mb;
    longint m;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    m = longint'(wide_product_shift(ma, mb, 40));
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Sine of an angle in degrees with fb fraction bits, Q40 result.
  function automatic longint sine_of_degrees(longint x, int fb);
    longint full_turn;
    longint half_turn;
    longint quarter_turn;
    longint r;
    longint xr;
    longint x2;
    longint term;
    longint sum;
    bit neg;
    full_turn = longint'(360) << fb;
    half_turn = longint'(180) << fb;
    quarter_turn = longint'(90) << fb;
    neg = 1'b0;
    r = x % full_turn;
    if (r < 0) r += full_turn;
    if (r >= half_turn) begin
      neg = 1'b1;
      r -= half_turn;
    end
    if (r > quarter_turn) r = half_turn - r;
    xr = longint'(wide_product_shift(64'(r), PI_DEG_Q60, 60 + fb - 40));
    x2 = q40_mul(xr, xr);
    term = xr;
    sum = xr;
    for (int n = 1; n <= 8; n++) begin
      term = q40_mul(term, x2) / longint'((2 * n) * (2 * n + 1));
      term = -term;
      sum += term;
    end
    return neg ? -sum : sum;
  endfunction

  // Floor square root of a Q40 value in [0,1].
  function automatic longint q40_sqrt(longint h);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] pair;
    rem = 0;
    root = 0;
    for (int i = 39; i >= 0; i--) begin
      pair = (i >= 20) ? ((64'(h) >> (2 * (i - 20))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  // Arcsine series for arguments up to sqrt(1/2).
  function automatic longint arcsine_series(longint s);
    longint s2;
    longint t;
    longint sum;
    s2 = q40_mul(s, s);
    t = s;
    sum = s;
    for (int n = 1; n <= 48; n++) begin
      t = q40_mul(t, s2) * longint'(2 * n - 1) / longint'(2 * n);
      sum += t / longint'(2 * n + 1);
    end
    return sum;
  endfunction

  // Haversine distance in km * 2^DFB for one pair of positions.
  function automatic logic [31:0] predict_distance(longint lat1, longint lon1, longint lat2,
                                                   longint lon2, logic [15:0] radius);
    longint u;
    longint v;
    longint c1;
    longint c2;
    longint h;
    longint ang;
    logic [63:0] d;
    u = sine_of_degrees(lat2 - lat1, AFB + 1);
    v = sine_of_degrees(lon2 - lon1, AFB + 1);
    c1 = sine_of_degrees(lat1 + (longint'(90) << AFB), AFB);
    c2 = sine_of_degrees(lat2 + (longint'(90) << AFB), AFB);
    h = q40_mul(u, u) + q40_mul(q40_mul(c1, c2), q40_mul(v, v));
    if (h < 0) h = 0;
    if (h > FIX_ONE_L) h = FIX_ONE_L;
    if (h <= FIX_ONE_L / 2) begin
      ang = arcsine_series(q40_sqrt(h));
    end else begin
      ang = longint'(PI_Q60 >> 21) - arcsine_series(q40_sqrt(FIX_ONE_L - h));
    end
    if (ang < 0) ang = 0;
    d = wide_product_shift(64'(ang), 64'(radius) * 64'd2, 40 - DFB);
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    return d[31:0];
  endfunction

  // Monitor: track radius writes, predict on each accepted item, check each result.
  always @(posedge clk) begin
    if (rst) begin
      radius_km = RADIUS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) radius_km = cfg_data;
      if (start && !busy) begin
        distance_queue.push_back(predict_distance(longint'(first_latitude),
          longint'(first_longitude), longint'(second_latitude),
          longint'(second_longitude), radius_km));
      end
      if (done) begin
        results_seen++;
        if (distance_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual distance %0d", $time, distance);
        end else begin
          logic [31:0] want;
          want = distance_queue.pop_front();
          if (distance !== want) begin
            errors++;
            $display("%0t: distance mismatch, expected %0d actual %0d", $time, want, distance);
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, distance_queue.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Send one item and hold it until accepted, then maybe idle for a while.
  // Short gaps keep the input idle in roughly a fifth of the cycles.
  task automatic send_positions(longint lat1, longint lon1, longint lat2, longint lon2);
    int gap;
    first_latitude <= (AFB + 8)'(lat1);
    first_longitude <= (AFB + 9)'(lon1);
    second_latitude <= (AFB + 8)'(lat2);
    second_longitude <= (AFB + 9)'(lon2);
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    if (idle_enable && $urandom_range(99) < 14) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lower start and wait until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the radius register while the unit is idle.
  task automatic write_radius(logic [15:0] value);
    drain_results();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radius_writes++;
  endtask

  // Field extremes, poles, antipodes and wrapped coordinates at the reset radius.
  task automatic test_directed();
    longint lat_max;
    longint lon_max;
    lat_max = (longint'(1) << (AFB + 7)) - 1;
    lon_max = (longint'(1) << (AFB + 8)) - 1;
    send_positions(0, 0, 0, 0);
    send_positions(45 * DEG, 10 * DEG, 45 * DEG, 10 * DEG);
    send_positions(0, 0, 0, 180 * DEG);
    send_positions(90 * DEG, 0, -90 * DEG, 0);
    send_positions(90 * DEG, 0, 90 * DEG, 123 * DEG);
    send_positions(-90 * DEG, -180 * DEG, 90 * DEG, 180 * DEG);
    send_positions(0, -180 * DEG, 0, 180 * DEG);
    send_positions(10 * DEG, 20 * DEG, -10 * DEG, -160 * DEG);
    send_positions(1, 0, 0, 1);
    send_positions(lat_max, lon_max, -lat_max - 1, -lon_max - 1);
    send_positions(-lat_max - 1, -lon_max - 1, lat_max, lon_max);
    send_positions(lat_max, 0, lat_max, lon_max);
    send_positions(100 * DEG, 0, 80 * DEG, 0);
    send_positions(120 * DEG, 30 * DEG, 0, 200 * DEG);
    send_positions(51 * DEG, 0, 40 * DEG, -74 * DEG);
    send_positions(-33 * DEG, 151 * DEG, 35 * DEG, 139 * DEG);
    send_positions(89 * DEG, 0, -89 * DEG, 180 * DEG);
    drain_results();
  endtask

  // A few items at each extreme and typical radius.
  task automatic test_radius_sweep();
    logic [15:0] radii[5];
    radii = '{16'd0, 16'd1, 16'd65535, 16'd1234, RADIUS_RESET};
    foreach (radii[k]) begin
      write_radius(radii[k]);
      send_positions(0, 0, 0, 180 * DEG);
      send_positions(90 * DEG, 0, -90 * DEG, 0);
      send_positions(12 * DEG, 34 * DEG, -56 * DEG, 78 * DEG);
      send_positions(0, 0, 0, 0);
    end
    drain_results();
  endtask

  // Random item: mostly valid positions, some near-equal or near-antipodal, some raw bits.
  task automatic send_random_item();
    longint lat1;
    longint lon1;
    longint lat2;
    longint lon2;
    int kind;
    kind = $urandom_range(99);
    lat1 = longint'($urandom_range(180 * DEG)) - 90 * DEG;
    lon1 = longint'($urandom_range(360 * DEG)) - 180 * DEG;
    lat2 = longint'($urandom_range(180 * DEG)) - 90 * DEG;
    lon2 = longint'($urandom_range(360 * DEG)) - 180 * DEG;
    if (kind < 12) begin
      lat2 = lat1 + longint'($urandom_range(2000)) - 1000;
      lon2 = lon1 + longint'($urandom_range(2000)) - 1000;
    end else if (kind < 22) begin
      lat2 = -lat1 + longint'($urandom_range(2000)) - 1000;
      lon2 = lon1 + 180 * DEG + longint'($urandom_range(2000)) - 1000;
    end else if (kind < 37) begin
      lat1 = longint'(signed'((AFB + 8)'($urandom())));
      lon1 = longint'(signed'((AFB + 9)'($urandom())));
      lat2 = longint'(signed'((AFB + 8)'($urandom())));
      lon2 = longint'(signed'((AFB + 9)'($urandom())));
    end
    send_positions(lat1, lon1, lat2, lon2);
  endtask

  // Random stream, with a middle stretch sent back to back, at two radii.
  task automatic test_random_stream();
    write_radius(16'($urandom_range(1, 65535)));
    for (int i = 0; i < 300; i++) begin
      idle_enable = !(i >= 100 && i < 250);
      send_random_item();
    end
    idle_enable = 1'b1;
    write_radius(RADIUS_RESET);
    for (int i = 0; i < 300; i++) send_random_item();
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_radius_sweep();
    test_random_stream();
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d items, checked %0d distances, %0d radius writes.",
             items_sent, results_seen, radius_writes);
    $display("Covered poles, antipodes, wrapped coordinates and radii 0, 1 and 65535.");
    if (errors == 0 && distance_queue.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/gcd_pkg.sv
rtl/core/gcd_mul.sv
rtl/core/gcd_trig_cell.sv
rtl/core/gcd_sin.sv
rtl/core/gcd_sqrt_cell.sv
rtl/core/gcd_asin_cell.sv
rtl/core/great_circle_distance_top.sv
verif/tb_top.sv
